/* src/gmd_pkg.sv */
// Shared types, constants and helpers for the gossip message dedup block.
`timescale 1ns / 1ps

package gmd_pkg;

  localparam int SEQ_SPAN   = 256;
  localparam int WORD_W     = 32;
  localparam int SEQ_WORDS  = SEQ_SPAN / WORD_W;
  localparam int WORD_SEL_W = $clog2(SEQ_WORDS);
  localparam int BIT_SEL_W  = $clog2(WORD_W);
  localparam int SEQ_W      = 9;
  localparam int SLOT_W     = 8;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [SEQ_W-1:0]  next_seq;
    logic [SLOT_W-1:0] log_slot;
  } result_t;

  // {found, index} of the lowest clear bit in a bitmap word
  function automatic logic [BIT_SEL_W:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic       hit;
    logic [1:0] b;
    logic [2:0] k;
    logic [7:0] byt;
    hit = 1'b0;
    b   = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (w[i*8 +: 8] != 8'hFF) begin
        hit = 1'b1;
        b   = 2'(i);
      end
    end
    byt = w[{b, 3'b000} +: 8];
    k   = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!byt[j]) begin
        k = 3'(j);
      end
    end
    return {hit, b, k};
  endfunction

endpackage

/* src/gmd_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps

module gmd_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/gmd_ctrl.sv */
// Sequencer: RAM clear after reset, lookup, duplicate check, bitmap update and next-gap scan.
`timescale 1ns / 1ps

module gmd_ctrl import gmd_pkg::*; #(
  parameter int NUM_SOURCES = 16,
  parameter int LOG_DEPTH   = 256
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_mode,
  input  logic [3:0]                                in_origin,
  input  logic [SEQ_W-1:0]                          in_seqnum,
  output logic                                      res_valid,
  input  logic                                      res_ready,
  output result_t                                   res,
  output logic                                      seen_we,
  output logic [$clog2(NUM_SOURCES)+WORD_SEL_W-1:0] seen_waddr,
  output logic [WORD_W-1:0]                         seen_wdata,
  output logic [$clog2(NUM_SOURCES)+WORD_SEL_W-1:0] seen_raddr,
  input  logic [WORD_W-1:0]                         seen_rdata,
  output logic                                      ne_we,
  output logic [$clog2(NUM_SOURCES)-1:0]            ne_waddr,
  output logic [SEQ_W-1:0]                          ne_wdata,
  output logic [$clog2(NUM_SOURCES)-1:0]            ne_raddr,
  input  logic [SEQ_W-1:0]                          ne_rdata
);

  localparam int SRC_W      = $clog2(NUM_SOURCES);
  localparam int ADDR_W     = SRC_W + WORD_SEL_W;
  localparam int SEEN_DEPTH = NUM_SOURCES * SEQ_WORDS;
  localparam int CNT_W      = $clog2(LOG_DEPTH + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                  state;
  logic                    mode_q;
  logic [SRC_W-1:0]        src_q;
  logic                    src_ok;
  logic [SEQ_W-1:0]        seq_q;
  logic [WORD_SEL_W-1:0]   word_idx;
  logic [CNT_W-1:0]        log_count;
  logic [ADDR_W-1:0]       clr_addr;
  result_t                 res_q;

  logic [6:0]              origin_ext;
  logic [SRC_W-1:0]        in_src;
  logic                    in_src_ok;
  logic [7:0]              in_pos;
  logic [7:0]              pos;
  logic                    seq_bad;
  logic                    bit_hit;
  logic                    full;
  logic                    is_dup;
  logic                    store;
  logic [WORD_W-1:0]       set_word;
  logic [BIT_SEL_W:0]      lz_look;
  logic [BIT_SEL_W:0]      lz_scan;
  logic [CNT_W+7:0]        cnt_ext;

  assign origin_ext = 7'(in_origin);
  assign in_src     = origin_ext[SRC_W-1:0];
  assign in_src_ok  = origin_ext < 7'(NUM_SOURCES);
  assign in_pos     = in_seqnum[7:0] - 8'd1;

  assign pos      = seq_q[7:0] - 8'd1;
  assign seq_bad  = (seq_q == '0) || (seq_q[8] && (seq_q[7:0] != 8'd0));
  assign bit_hit  = seen_rdata[pos[BIT_SEL_W-1:0]];
  assign full     = log_count >= CNT_W'(LOG_DEPTH);
  assign is_dup   = !mode_q && ((seq_q < ne_rdata) || bit_hit);
  assign store    = (state == S_LOOK) && src_ok && !seq_bad && !is_dup && !full;
  assign set_word = seen_rdata | (WORD_W'(1) << pos[BIT_SEL_W-1:0]);
  assign lz_look  = lowest_zero(set_word);
  assign lz_scan  = lowest_zero(seen_rdata);
  assign cnt_ext  = (CNT_W + 8)'(log_count);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  always_comb begin
    unique case (state)
      S_IDLE:  seen_raddr = {in_src, in_pos[7:BIT_SEL_W]};
      S_LOOK:  seen_raddr = {src_q, pos[7:BIT_SEL_W] + WORD_SEL_W'(1)};
      default: seen_raddr = {src_q, word_idx + WORD_SEL_W'(1)};
    endcase
  end

  assign ne_raddr   = in_src;
  assign seen_we    = (state == S_CLEAR) || store;
  assign seen_waddr = (state == S_CLEAR) ? clr_addr : {src_q, pos[7:BIT_SEL_W]};
  assign seen_wdata = (state == S_CLEAR) ? '0 : set_word;
  assign ne_we      = (state == S_CLEAR) || ((state == S_DONE) && src_ok);
  assign ne_waddr   = (state == S_CLEAR) ? clr_addr[ADDR_W-1:WORD_SEL_W] : src_q;
  assign ne_wdata   = (state == S_CLEAR) ? SEQ_W'(1) : res_q.next_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      log_count <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(SEEN_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= in_mode;
            src_q  <= in_src;
            src_ok <= in_src_ok;
            seq_q  <= in_seqnum;
            state  <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_q.log_slot <= '0;
          res_q.next_seq <= ne_rdata;
          state          <= S_DONE;
          if (!src_ok) begin
            res_q.status   <= ST_INVALID;
            res_q.next_seq <= SEQ_W'(1);
          end else if (seq_bad) begin
            res_q.status <= ST_INVALID;
          end else if (is_dup) begin
            res_q.status <= ST_DUP;
          end else if (full) begin
            res_q.status <= ST_FULL;
          end else begin
            res_q.status   <= ST_STORED;
            res_q.log_slot <= cnt_ext[7:0];
            log_count      <= log_count + CNT_W'(1);
            if (seq_q == ne_rdata) begin
              if (lz_look[BIT_SEL_W]) begin
                res_q.next_seq <= {1'b0, pos[7:BIT_SEL_W], lz_look[BIT_SEL_W-1:0]}
                                  + SEQ_W'(1);
              end else if (pos[7:BIT_SEL_W] == WORD_SEL_W'(SEQ_WORDS - 1)) begin
                res_q.next_seq <= SEQ_W'(SEQ_SPAN + 1);
              end else begin
                word_idx <= pos[7:BIT_SEL_W] + WORD_SEL_W'(1);
                state    <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          if (lz_scan[BIT_SEL_W]) begin
            res_q.next_seq <= {1'b0, word_idx, lz_scan[BIT_SEL_W-1:0]} + SEQ_W'(1);
            state          <= S_DONE;
          end else if (word_idx == WORD_SEL_W'(SEQ_WORDS - 1)) begin
            res_q.next_seq <= SEQ_W'(SEQ_SPAN + 1);
            state          <= S_DONE;
          end else begin
            word_idx <= word_idx + WORD_SEL_W'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/gossip_message_dedup_clock.sv */
// Top level: gossip message de-duplicator with per-origin next-expected clock.
`timescale 1ns / 1ps

// One message identity is taken per beat and gives one result beat. An item
// passes through accept, bitmap/clock lookup and result. When the stored
// sequence number closes the origin's lowest gap and leaves the same 32-bit
// bitmap word full, and that word is not the last, a next-gap scan runs
// between lookup and result; it reads one further bitmap word per cycle,
// up to 7 more, through the single read port of the bitmap RAM.
// After reset the block clears both RAMs and holds s_tready low meanwhile.
// A finished result sits in the output register, and the next item is
// taken while it waits.
module gossip_message_dedup_clock import gmd_pkg::*; #(
  parameter int NUM_SOURCES = 16,
  parameter int LOG_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // origin[3:0], seqnum[12:4], zero fill
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // next_seq[8:0], log_slot[16:9], zero fill
  output logic [1:0]  m_tuser    // status
);

  localparam int SRC_W      = $clog2(NUM_SOURCES);
  localparam int ADDR_W     = SRC_W + WORD_SEL_W;
  localparam int SEEN_DEPTH = NUM_SOURCES * SEQ_WORDS;

  logic                res_valid;
  logic                res_ready;
  result_t             res;
  logic                seen_we;
  logic [ADDR_W-1:0]   seen_waddr;
  logic [WORD_W-1:0]   seen_wdata;
  logic [ADDR_W-1:0]   seen_raddr;
  logic [WORD_W-1:0]   seen_rdata;
  logic                ne_we;
  logic [SRC_W-1:0]    ne_waddr;
  logic [SEQ_W-1:0]    ne_wdata;
  logic [SRC_W-1:0]    ne_raddr;
  logic [SEQ_W-1:0]    ne_rdata;

  gmd_ctrl #(
    .NUM_SOURCES(NUM_SOURCES),
    .LOG_DEPTH  (LOG_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_origin (s_tdata[3:0]),
    .in_seqnum (s_tdata[12:4]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .seen_we   (seen_we),
    .seen_waddr(seen_waddr),
    .seen_wdata(seen_wdata),
    .seen_raddr(seen_raddr),
    .seen_rdata(seen_rdata),
    .ne_we     (ne_we),
    .ne_waddr  (ne_waddr),
    .ne_wdata  (ne_wdata),
    .ne_raddr  (ne_raddr),
    .ne_rdata  (ne_rdata)
  );

  gmd_ram #(
    .DEPTH(SEEN_DEPTH),
    .WIDTH(WORD_W)
  ) u_seen_ram (
    .clk  (clk),
    .we   (seen_we),
    .waddr(seen_waddr),
    .wdata(seen_wdata),
    .raddr(seen_raddr),
    .rdata(seen_rdata)
  );

  gmd_ram #(
    .DEPTH(NUM_SOURCES),
    .WIDTH(SEQ_W)
  ) u_next_ram (
    .clk  (clk),
    .we   (ne_we),
    .waddr(ne_waddr),
    .wdata(ne_wdata),
    .raddr(ne_raddr),
    .rdata(ne_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {7'd0, res.log_slot, res.next_seq};
      m_tuser <= res.status;
    end
  end

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_slot_only_when_stored: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_STORED) |-> m_tdata[16:9] == 8'd0)
    else $error("log slot set on a beat that stored nothing");

  a_next_seq_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:0] != 9'd0) && (m_tdata[8:0] <= 9'd257))
    else $error("next expected sequence number out of range");

endmodule

/* sim/gmd_checker.sv */
// Checker for the gossip dedup block: predicts each result beat and compares it.
`timescale 1ns / 1ps

module gmd_checker import gmd_pkg::*; #(
  parameter int NUM_SOURCES = 16,
  parameter int LOG_DEPTH   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // origin[3:0], seqnum[12:4], zero fill
  input  logic        s_tuser,   // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // next_seq[8:0], log_slot[16:9], zero fill
  input  logic [1:0]  m_tuser,   // status
  output int          fails,
  output int          outstanding
);

  logic [SEQ_SPAN-1:0] held_bits [NUM_SOURCES];
  logic [SEQ_W-1:0]    clock_next [NUM_SOURCES];
  int unsigned         log_fill;
  result_t             verdicts_q [$];
  int                  bad;

  function automatic result_t judge_message(input logic md, input logic [3:0] org,
                                            input logic [SEQ_W-1:0] sq);
    result_t     r;
    int unsigned gap_at;
    r.status   = ST_STORED;
    r.log_slot = '0;
    if (sq == 0 || sq > SEQ_SPAN) begin
      r.status = ST_INVALID;
    end else if (!md && (sq < clock_next[org] || held_bits[org][sq-1])) begin
      r.status = ST_DUP;
    end else if (log_fill >= LOG_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      r.log_slot = log_fill[SLOT_W-1:0];
      log_fill++;
      held_bits[org][sq-1] = 1'b1;
      // lowest sequence number still missing, or one past the span
      gap_at = SEQ_SPAN + 1;
      for (int s = SEQ_SPAN; s >= 1; s--) begin
        if (!held_bits[org][s-1]) begin
          gap_at = s;
        end
      end
      clock_next[org] = gap_at[SEQ_W-1:0];
    end
    r.next_seq = clock_next[org];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int o = 0; o < NUM_SOURCES; o++) begin
        held_bits[o]  = '0;
        clock_next[o] = SEQ_W'(1);
      end
      log_fill = 0;
      verdicts_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        verdicts_q.push_back(judge_message(s_tuser, s_tdata[3:0], s_tdata[12:4]));
      end
      if (m_tvalid && m_tready) begin
        if (verdicts_q.size() == 0) begin
          bad++;
          if (bad <= 10) begin
            $display("unexpected result beat: status %0d next %0d slot %0d",
                     m_tuser, m_tdata[8:0], m_tdata[16:9]);
          end
        end else begin
          want = verdicts_q.pop_front();
          if (m_tuser != want.status || m_tdata[8:0] != want.next_seq ||
              m_tdata[16:9] != want.log_slot) begin
            bad++;
            if (bad <= 10) begin
              $display("mismatch: want st %0d nx %0d sl %0d, got st %0d nx %0d sl %0d",
                       want.status, want.next_seq, want.log_slot,
                       m_tuser, m_tdata[8:0], m_tdata[16:9]);
            end
          end
        end
      end
    end
    outstanding <= verdicts_q.size();
    fails       <= bad;
  end

endmodule

/* sim/tb.sv */
// Testbench top: drives message beats into the dedup block and reports the verdict.
`timescale 1ns / 1ps

module tb;
  import gmd_pkg::*;

  localparam int ITEMS       = 900;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fails;
  int          outstanding;

  int          in_count = 0;
  int          cycles = 0;
  bit          sent_map [16][0:SEQ_SPAN];
  int          frontier [16];

  gossip_message_dedup_clock u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  gmd_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // no idling on either side in every fourth block of 64 beats
  function automatic bit calm();
    return ((in_count / 64) % 4) == 3;
  endfunction

  task automatic offer_msg(input logic md, input logic [3:0] org, input int sq);
    int gap;
    int r;
    gap = 0;
    if (!calm()) begin
      r = $urandom_range(0, 99);
      if (r >= 90) begin
        gap = $urandom_range(12, 40);
      end else if (r >= 50) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, 9'(sq), org};
    s_tuser  <= md;
    do @(posedge clk); while (!s_tready);
    in_count++;
    if (sq >= 1 && sq <= SEQ_SPAN) begin
      sent_map[org][sq] = 1'b1;
      while (frontier[org] <= SEQ_SPAN && sent_map[org][frontier[org]]) begin
        frontier[org]++;
      end
    end
  endtask

  initial begin : sink
    int stall;
    int holds;
    stall = 0;
    holds = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (holds < 2 && in_count >= 150 + 370 * holds) begin
        // long hold so the block backs up into its input
        holds++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!calm() && $urandom_range(0, 2) == 0) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 50) : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin : stim
    int         kind;
    int         sq;
    int         f;
    int         k;
    logic       md;
    logic [3:0] org;
    for (int o = 0; o < 16; o++) begin
      frontier[o] = 1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // invalid sequence numbers, zero and oversize
    offer_msg(1'b0, 4'd0, 0);
    offer_msg(1'b1, 4'd15, 0);
    offer_msg(1'b0, 4'd3, 257);
    offer_msg(1'b1, 4'd9, 511);
    // store, peer duplicate, local repeat
    offer_msg(1'b0, 4'd0, 1);
    offer_msg(1'b0, 4'd0, 1);
    offer_msg(1'b1, 4'd0, 1);
    // gap closes and next expected jumps
    offer_msg(1'b0, 4'd0, 3);
    offer_msg(1'b0, 4'd0, 2);
    offer_msg(1'b0, 4'd0, 2);
    offer_msg(1'b0, 4'd0, 3);
    offer_msg(1'b1, 4'd0, 2);
    // top of the span, set bit above next expected
    offer_msg(1'b0, 4'd15, 256);
    offer_msg(1'b0, 4'd15, 256);
    offer_msg(1'b1, 4'd15, 256);
    offer_msg(1'b0, 4'd15, 1);
    offer_msg(1'b0, 4'd15, 33);
    offer_msg(1'b1, 4'd15, 33);
    offer_msg(1'b0, 4'd10, 170);
    offer_msg(1'b1, 4'd5, 85);

    while (in_count < ITEMS) begin
      kind = $urandom_range(0, 99);
      org  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                          : 4'($urandom_range(0, 15));
      if (kind < 50) begin
        sq = frontier[org] + $urandom_range(0, 40);
        if (sq > SEQ_SPAN) sq = SEQ_SPAN;
        md = ($urandom_range(0, 4) == 0);
        offer_msg(md, org, sq);
      end else if (kind < 54) begin
        // fill ahead of the gap, then close it: scan can run over several words
        f = frontier[org];
        k = $urandom_range(2, 48);
        for (int i = 1; i <= k; i++) begin
          offer_msg(1'b0, org, (f + i > SEQ_SPAN) ? SEQ_SPAN : f + i);
        end
        md = 1'($urandom_range(0, 1));
        offer_msg(md, org, (f > SEQ_SPAN) ? SEQ_SPAN : f);
      end else if (kind < 80) begin
        f  = frontier[org] + 40;
        sq = $urandom_range(1, (f > SEQ_SPAN) ? SEQ_SPAN : f);
        md = ($urandom_range(0, 5) == 0);
        offer_msg(md, org, sq);
      end else begin
        org = 4'($urandom_range(0, 15));
        sq  = $urandom_range(0, 511);
        md  = 1'($urandom_range(0, 1));
        offer_msg(md, org, sq);
      end
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/gmd_pkg.sv
src/gmd_ram.sv
src/gmd_ctrl.sv
src/gossip_message_dedup_clock.sv
sim/gmd_checker.sv
sim/tb.sv
